// ===== hw/rtl/gfau_pkg.sv =====
// shared types, constants and field arithmetic for the gf(2^8) arithmetic unit
package gfau_pkg;

    localparam logic [7:0] GF_REDUCE = 8'h1D;
    localparam int unsigned CHAIN_LEN = 7;

    localparam logic [1:0] KIND_MUL = 2'd0;
    localparam logic [1:0] KIND_DIV = 2'd1;
    localparam logic [1:0] KIND_INV = 2'd2;

    // one word travelling down the power chain
    typedef struct packed {
        logic       en;
        logic [7:0] acc;
        logic [7:0] base;
        logic [7:0] mul;
    } gfau_word_t;

    // carry-less multiply reduced modulo x^8+x^4+x^3+x^2+1
    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 7; i >= 0; i--)
        begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? GF_REDUCE : 8'h00);
            if (x[i])
            begin
                acc = acc ^ y;
            end
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_sq(input logic [7:0] x);
        return gf_mul(x, x);
    endfunction

endpackage

// ===== hw/rtl/gf256_arithmetic_unit_top.sv =====
// gf(2^8) multiply, divide and inverse unit built as a chain of power cells
// stages: 7 power cells and one output stage, each holding its word in a register
// throughput: one word per cycle while rsp_stall is low; each cell passes its word on whenever the next one is free
// the inverse is b^254 or a^254 formed by square-and-multiply, one exponent bit per cell
// reset: rst_n asynchronous active low empties all cells and the output register
module gf256_arithmetic_unit_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] kind,
    input  logic [7:0] a,
    input  logic [7:0] b,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [7:0] result
);
    import gfau_pkg::*;

    logic       valid_chain [CHAIN_LEN+1];
    logic       ready_chain [CHAIN_LEN+1];
    gfau_word_t word_chain  [CHAIN_LEN+1];
    gfau_word_t entry_word;

    logic       rsp_valid_reg;
    logic [7:0] result_reg;
    logic       out_ready;

    // entry word: base is the square of the element to raise to 254, mul the final factor (multiply: en off, acc = b)
    always_comb
    begin
        entry_word.en   = 1'b1;
        entry_word.acc  = 8'h01;
        entry_word.base = gf_sq(b);
        entry_word.mul  = a;
        case (kind)
            KIND_MUL:
            begin
                entry_word.en  = 1'b0;
                entry_word.acc = b;
            end
            KIND_DIV:
            begin
                entry_word.mul = a;
            end
            KIND_INV:
            begin
                entry_word.base = gf_sq(a);
                entry_word.mul  = 8'h01;
            end
            default:
            begin
                entry_word.mul = 8'h00;
            end
        endcase
    end

    assign word_chain[0]  = entry_word;
    assign valid_chain[0] = req_valid;
    assign req_stall      = !ready_chain[0];

    for (genvar i = 0; i < CHAIN_LEN; i++)
    begin : g_cell
        gfau_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_chain[i]),
            .up_word  (word_chain[i]),
            .up_ready (ready_chain[i]),
            .dn_valid (valid_chain[i+1]),
            .dn_word  (word_chain[i+1]),
            .dn_ready (ready_chain[i+1])
        );
    end

    assign out_ready              = !rsp_valid_reg || !rsp_stall;
    assign ready_chain[CHAIN_LEN] = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            rsp_valid_reg <= valid_chain[CHAIN_LEN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && valid_chain[CHAIN_LEN])
        begin
            result_reg <= gf_mul(word_chain[CHAIN_LEN].acc, word_chain[CHAIN_LEN].mul);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign result    = result_reg;

endmodule

// ===== hw/rtl/gfau_cell.sv =====
// one cell of the power chain: multiplies the base into the accumulator when en is set and squares the base
module gfau_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    input  gfau_pkg::gfau_word_t up_word,
    output logic                up_ready,
    output logic                dn_valid,
    output gfau_pkg::gfau_word_t dn_word,
    input  logic                dn_ready
);
    import gfau_pkg::*;

    logic       valid_reg;
    gfau_word_t word_reg;
    gfau_word_t word_next;
    logic       load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    always_comb
    begin
        word_next      = up_word;
        word_next.acc  = up_word.en ? gf_mul(up_word.acc, up_word.base) : up_word.acc;
        word_next.base = gf_sq(up_word.base);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (dn_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dn_ready |=> valid_reg && $stable(word_reg))
        else $error("cell word changed while blocked");

    a_empty_takes_word: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> up_ready)
        else $error("empty cell refused a word");

    a_zero_base_kills_acc: assert property (@(posedge clk) disable iff (!rst_n)
        load && up_word.en && up_word.base == 8'h00 |=> word_reg.acc == 8'h00)
        else $error("zero base left a nonzero accumulator");

endmodule
